// ===== design/rbcp_pkg.sv =====
// shared types, constants and decode functions for the register bank conflict penalty block
// no dependencies; imported by every module of the block
package rbcp_pkg;

   // number of operand format suffix codes that have a decode entry
   localparam int unsigned NUM_SUFFIX = 79;

   // bank count; each bank's register count is divided by BANKS to give its share of the penalty
   localparam int unsigned BANKS = 2;

   // register write classes, also stored as the per-thread write kind
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_ONE  = 2'd1;
   localparam logic [1:0] WR_PAIR = 2'd2;
   localparam logic [1:0] WR_BAD  = 2'd3;

   // suffix codes that bound the read classes
   localparam logic [6:0] LAST_RD_A   = 7'd43;
   localparam logic [6:0] LAST_RD_AB  = 7'd65;
   localparam logic [6:0] LAST_RD_ADB = 7'd67;
   localparam logic [6:0] LAST_RD_NONE = 7'd77;

   // register read classes
   typedef enum logic [2:0] {
      RD_NONE,
      RD_A,
      RD_AB,
      RD_ADB,
      RD_DB
   } rd_class_type;

   // one issued instruction as packed on the request channel, first field highest
   typedef struct packed {
      logic [3:0] dc_pair;
      logic [3:0] db_pair;
      logic [4:0] rc_index;
      logic [4:0] rb_index;
      logic       rb_is_reg;
      logic [4:0] ra_index;
      logic       ra_is_reg;
      logic [6:0] suffix_code;
      logic [3:0] thread_id;
   } req_type;

   localparam int unsigned REQ_BITS = $bits(req_type);

   // per-thread record of what the previous instruction wrote
   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] index;
   } entry_type;

   // write class of every decoded suffix, in code order
   localparam logic [1:0] WR_CLASS_TABLE [NUM_SUFFIX] = '{
      2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2,
      2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1,
      2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
      2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
      2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0,
      2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0,
      2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1,
      2'd0, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0, 2'd0, 2'd2
   };

   // write class of a suffix; codes past the table decode as bad
   function automatic logic [1:0] wr_class_of(input logic [6:0] code);
      logic [1:0] cls;
      cls = WR_BAD;
      if (code < 7'(NUM_SUFFIX)) begin
         cls = WR_CLASS_TABLE[code];
      end
      return cls;
   endfunction

   // read class of a suffix, set by code ranges
   function automatic rd_class_type rd_class_of(input logic [6:0] code);
      rd_class_type cls;
      if (code <= LAST_RD_A) begin
         cls = RD_A;
      end else if (code <= LAST_RD_AB) begin
         cls = RD_AB;
      end else if (code <= LAST_RD_ADB) begin
         cls = RD_ADB;
      end else if (code <= LAST_RD_NONE) begin
         cls = RD_NONE;
      end else begin
         cls = RD_DB;
      end
      return cls;
   endfunction

   // one-hot mask of a single register
   function automatic logic [31:0] single_mask(input logic [4:0] idx);
      return 32'd1 << idx;
   endfunction

   // mask of register pair k: registers 2k and 2k+1
   function automatic logic [31:0] pair_mask(input logic [3:0] k);
      return 32'd3 << {k, 1'b0};
   endfunction

endpackage

// ===== design/rbcp_state_mem.sv =====
// per-thread last-write memory: one write port, one read port, registered read data
// depends on rbcp_pkg for the entry type; valid bits stand in for the reset value
module rbcp_state_mem #(
   parameter int unsigned THREADS = 16,
   parameter int unsigned TW      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [TW-1:0]         rd_addr,
   output rbcp_pkg::entry_type   rd_entry,
   input  logic                  wr_en,
   input  logic [TW-1:0]         wr_addr,
   input  rbcp_pkg::entry_type   wr_entry
);
   import rbcp_pkg::*;

   entry_type              entry_mem [THREADS];
   logic [THREADS-1:0]     valid_ff;
   logic [THREADS-1:0]     valid_in;
   entry_type              rd_entry_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
   end

   // valid bits: an entry never written reads as no write
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // registered read, held while no new read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (valid_ff[rd_addr]) begin
            rd_entry_ff <= entry_mem[rd_addr];
         end else begin
            rd_entry_ff <= '0;
         end
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== design/rbcp_penalty.sv =====
// suffix decode, register set merge, bank count and write-back entry for one instruction
// depends on rbcp_pkg for decode tables and types
module rbcp_penalty (
   input  rbcp_pkg::req_type    req,
   input  logic                 known,
   input  rbcp_pkg::entry_type  prev,
   output logic [1:0]           extra_cycles,
   output logic                 bad_suffix,
   output logic                 store,
   output rbcp_pkg::entry_type  next_entry
);
   import rbcp_pkg::*;

   rd_class_type   rcls;
   logic [1:0]     wcls;
   logic [31:0]    reg_set;
   logic [4:0]     even_cnt;
   logic [4:0]     odd_cnt;
   logic [2:0]     sum;

   // decode
   assign rcls       = rd_class_of(req.suffix_code);
   assign wcls       = wr_class_of(req.suffix_code);
   assign bad_suffix = (wcls == WR_BAD);

   // previous writes of the thread joined with the current reads
   always_comb begin
      reg_set = '0;
      if (known) begin
         if (prev.kind == WR_ONE) begin
            reg_set = reg_set | single_mask(prev.index);
         end else if (prev.kind == WR_PAIR) begin
            reg_set = reg_set | pair_mask(prev.index[3:0]);
         end
      end
      if ((rcls == RD_A || rcls == RD_AB || rcls == RD_ADB) && req.ra_is_reg) begin
         reg_set = reg_set | single_mask(req.ra_index);
      end
      if (rcls == RD_AB && req.rb_is_reg) begin
         reg_set = reg_set | single_mask(req.rb_index);
      end
      if (rcls == RD_ADB || rcls == RD_DB) begin
         reg_set = reg_set | pair_mask(req.db_pair);
      end
   end

   // per-bank counts, each bank costs count / BANKS
   assign even_cnt = 5'($countones(reg_set & 32'h5555_5555));
   assign odd_cnt  = 5'($countones(reg_set & 32'hAAAA_AAAA));
   assign sum      = 3'(even_cnt / BANKS) + 3'(odd_cnt / BANKS);
   assign extra_cycles = bad_suffix ? 2'd0 : sum[1:0];

   // this instruction's writes become the thread's previous writes
   always_comb begin
      next_entry.kind = wcls;
      case (wcls)
         WR_ONE:  next_entry.index = req.rc_index;
         WR_PAIR: next_entry.index = {1'b0, req.dc_pair};
         default: next_entry.index = '0;
      endcase
   end

   assign store = known && !bad_suffix;

endmodule

// ===== design/regfile_bank_conflict_penalty.sv =====
// top level: request and result stream channels around the last-write memory and penalty logic
// depends on rbcp_pkg, rbcp_state_mem and rbcp_penalty
//
// channel | dir | handshake             | contents
// req     | in  | req_tvalid/req_tready | one issued instruction (40-bit tdata)
// rsp     | out | rsp_tvalid/rsp_tready | penalty, bad suffix flag, thread (8-bit tdata)
//
// one instruction per cycle unless rsp stalls; results pass decode stage and result register
// the memory read is registered; a thread entry is written back when the decode stage advances
// same thread on back-to-back transfers is served from a forwarding register, not the memory
// reset clears the valid bits of all entries at once; no clearing pass
// a stalled result register holds the decode stage, and a held full decode stage stalls req
module regfile_bank_conflict_penalty #(
   parameter int unsigned THREADS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // thread_id[3:0], suffix_code[10:4], ra_is_reg[11], ra_index[16:12], rb_is_reg[17],
   // rb_index[22:18], rc_index[27:23], db_pair[31:28], dc_pair[35:32], zero fill [39:36]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // extra_cycles[1:0], bad_suffix[2], thread_out[6:3], zero fill [7]
   output logic [7:0]  rsp_tdata
);
   import rbcp_pkg::*;

   localparam int unsigned TW = (THREADS > 1) ? $clog2(THREADS) : 1;

   req_type     req;
   logic        req_fire;
   logic        req_known;
   logic        s1_adv;

   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_req_ff, s1_req_in;
   logic        s1_known_ff, s1_known_in;
   logic        fwd_hit_ff, fwd_hit_in;
   entry_type   fwd_entry_ff, fwd_entry_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_extra_ff, rsp_extra_in;
   logic        rsp_bad_ff, rsp_bad_in;
   logic [3:0]  rsp_thread_ff, rsp_thread_in;

   entry_type   mem_entry;
   entry_type   prev;
   logic [1:0]  extra_cycles;
   logic        bad_suffix;
   logic        store;
   entry_type   next_entry;
   logic        wr_en;

   // request unpack and handshake
   assign req       = req_type'(req_tdata[REQ_BITS-1:0]);
   assign s1_adv    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_tvalid && req_tready;
   assign req_known = {1'b0, req.thread_id} < 5'(THREADS);

   // write back as the decode stage hands its result on
   assign wr_en = s1_valid_ff && s1_adv && store;

   rbcp_state_mem #(
      .THREADS (THREADS),
      .TW      (TW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (TW'(req.thread_id)),
      .rd_entry (mem_entry),
      .wr_en    (wr_en),
      .wr_addr  (TW'(s1_req_ff.thread_id)),
      .wr_entry (next_entry)
   );

   // forwarded entry wins over the memory read that missed the same-edge write
   assign prev = fwd_hit_ff ? fwd_entry_ff : mem_entry;

   rbcp_penalty u_penalty (
      .req          (s1_req_ff),
      .known        (s1_known_ff),
      .prev         (prev),
      .extra_cycles (extra_cycles),
      .bad_suffix   (bad_suffix),
      .store        (store),
      .next_entry   (next_entry)
   );

   // decode stage next state
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_req_in    = s1_req_ff;
      s1_known_in  = s1_known_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_entry_in = fwd_entry_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in  = 1'b1;
         s1_req_in    = req;
         s1_known_in  = req_known;
         fwd_hit_in   = wr_en && (s1_req_ff.thread_id == req.thread_id);
         fwd_entry_in = next_entry;
      end
   end

   // result register next state
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_extra_in  = rsp_extra_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_thread_in = rsp_thread_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_valid_ff && s1_adv) begin
         rsp_valid_in  = 1'b1;
         rsp_extra_in  = extra_cycles;
         rsp_bad_in    = bad_suffix;
         rsp_thread_in = s1_req_ff.thread_id;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_req_ff     <= s1_req_in;
      s1_known_ff   <= s1_known_in;
      fwd_entry_ff  <= fwd_entry_in;
      rsp_extra_ff  <= rsp_extra_in;
      rsp_bad_ff    <= rsp_bad_in;
      rsp_thread_ff <= rsp_thread_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_thread_ff, rsp_bad_ff, rsp_extra_ff};

   // a bad suffix never touches the thread's entry
   a_bad_no_write: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && bad_suffix) |-> !wr_en)
      else $error("entry written for a bad suffix");

   // forwarding only follows a write on the accepting edge
   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_hit_ff) |-> $past(wr_en))
      else $error("forward hit without a preceding write");

   // an empty result register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with an empty result register");

   // same-bank penalty never takes the value 3
   a_extra_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_extra_ff != 2'd3))
      else $error("penalty out of range");

endmodule
